// ===== design/smc_pkg.sv =====
package smc_pkg;

  // Shutter states, as reported on the result channel
  typedef enum logic [2:0] {
    SH_CLOSED  = 3'd0,
    SH_OPEN    = 3'd1,
    SH_OPENING = 3'd2,
    SH_CLOSING = 3'd3,
    SH_ABORTED = 3'd4,
    SH_FAULT   = 3'd5
  } state_t;

  // Pending command codes
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_CLOSE = 2'd2,
    CMD_ABORT = 2'd3
  } cmd_t;

  // Motor call codes
  typedef enum logic [1:0] {
    MOT_NONE  = 2'd0,
    MOT_OPEN  = 2'd1,
    MOT_CLOSE = 2'd2,
    MOT_STOP  = 2'd3
  } motor_t;

  localparam int unsigned CountW = 20;
  localparam logic [CountW-1:0] CountMax     = '1;
  localparam logic [CountW-1:0] TimeoutReset = CountW'(30000);

  // One update request as held in the input register
  typedef struct packed {
    cmd_t command;
    logic closed_switch;
    logic open_switch;
    logic ms_tick;
  } req_t;

  // Outcome of one update
  typedef struct packed {
    state_t            state;
    logic [CountW-1:0] elapsed;
    motor_t            motor;
    logic              changed;
  } upd_t;

endpackage

// ===== design/smc_in_stage.sv =====
module smc_in_stage
  import smc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic req_valid,
  input  logic req_take,
  output req_t req
);

  logic valid_r;
  logic valid_nxt;
  req_t req_r;

  // Register accepts a new request when empty or when its request moves on
  assign in_ready  = !valid_r || req_take;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !req_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_req;
    end
  end

  assign req_valid = valid_r;
  assign req       = req_r;

endmodule

// ===== design/smc_step.sv =====
module smc_step
  import smc_pkg::*;
(
  input  state_t            mode,
  input  logic [CountW-1:0] elapsed,
  input  logic [CountW-1:0] run_timeout,
  input  req_t              req,
  output upd_t              upd
);

  logic [CountW-1:0] el_inc;
  logic              in_run;
  logic              done_sw;
  logic              abort_hit;
  logic              timed_out;
  state_t            done_state;
  motor_t            drive;

  // Run bookkeeping: tick counts with saturation
  assign el_inc    = (req.ms_tick && elapsed != CountMax) ? elapsed + CountW'(1) : elapsed;
  assign in_run    = (mode == SH_OPENING);
  assign done_sw   = in_run ? req.open_switch : req.closed_switch;
  assign done_state = in_run ? SH_OPEN : SH_CLOSED;
  assign drive     = in_run ? MOT_OPEN : MOT_CLOSE;
  assign abort_hit = (req.command == CMD_ABORT) ||
                     (req.command == (in_run ? CMD_CLOSE : CMD_OPEN));
  assign timed_out = el_inc > run_timeout;

  always_comb begin
    upd.state   = mode;
    upd.elapsed = elapsed;
    upd.motor   = MOT_NONE;
    upd.changed = 1'b0;
    unique case (mode)
      SH_CLOSED: begin
        if (req.command == CMD_OPEN) begin
          upd.state   = SH_OPENING;
          upd.elapsed = '0;
          upd.changed = 1'b1;
        end
      end
      SH_OPEN: begin
        if (req.command == CMD_CLOSE) begin
          upd.state   = SH_CLOSING;
          upd.elapsed = '0;
          upd.changed = 1'b1;
        end
      end
      SH_OPENING, SH_CLOSING: begin
        upd.elapsed = el_inc;
        if (done_sw) begin
          upd.state   = done_state;
          upd.motor   = MOT_STOP;
          upd.changed = 1'b1;
        end else if (abort_hit) begin
          upd.state   = SH_ABORTED;
          upd.motor   = MOT_STOP;
          upd.changed = 1'b1;
        end else if (timed_out) begin
          upd.state   = SH_FAULT;
          upd.motor   = MOT_STOP;
          upd.changed = 1'b1;
        end else begin
          upd.motor = drive;
        end
      end
      default: begin
        // aborted, error and unused codes: re-read switches, then obey run commands
        if (req.closed_switch) begin
          upd.state = SH_CLOSED;
        end else if (req.open_switch) begin
          upd.state = SH_OPEN;
        end else begin
          upd.state = SH_ABORTED;
        end
        if (req.command == CMD_OPEN) begin
          upd.state   = SH_OPENING;
          upd.elapsed = '0;
          upd.changed = 1'b1;
        end else if (req.command == CMD_CLOSE) begin
          upd.state   = SH_CLOSING;
          upd.elapsed = '0;
          upd.changed = 1'b1;
        end
      end
    endcase
  end

endmodule

// ===== design/shutter_motor_controller_core.sv =====
// A request accepted into the input register moves to the result register when that one is
// free or draining (input register, then result register).
// Throughput: one request per cycle while the receiver is ready; the update is combinational.
// Reset (synchronous, rst_n low): state aborted, run count zero, run timeout 30000 ms,
// both pipeline registers empty.
module shutter_motor_controller_core
  import smc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CountW-1:0] cfg_run_timeout,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_command,
  input  logic              in_closed_switch,
  input  logic              in_open_switch,
  input  logic              in_ms_tick,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_shutter_state,
  output logic [1:0]        out_motor_cmd,
  output logic              out_status_changed
);

  req_t              in_req;
  req_t              req;
  logic              req_valid;
  logic              req_take;
  upd_t              upd;
  state_t            mode_r;
  logic [CountW-1:0] elapsed_r;
  logic [CountW-1:0] timeout_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  state_t            out_state_r;
  motor_t            out_motor_r;
  logic              out_changed_r;

  assign in_req = '{command: cmd_t'(in_command), closed_switch: in_closed_switch,
                    open_switch: in_open_switch, ms_tick: in_ms_tick};

  smc_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .req_valid (req_valid),
    .req_take  (req_take),
    .req       (req)
  );

  smc_step u_step (
    .mode        (mode_r),
    .elapsed     (elapsed_r),
    .run_timeout (timeout_r),
    .req         (req),
    .upd         (upd)
  );

  // Request moves to the result register when that register is free or draining
  assign req_take      = req_valid && (!out_valid_r || out_ready);
  assign out_valid_nxt = req_take || (out_valid_r && !out_ready);

  // Shutter state and run count commit with the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= SH_ABORTED;
      elapsed_r <= '0;
    end else if (req_take) begin
      mode_r    <= upd.state;
      elapsed_r <= upd.elapsed;
    end
  end

  // Timeout register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TimeoutReset;
    end else if (cfg_valid && cfg_ready) begin
      timeout_r <= cfg_run_timeout;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      out_state_r   <= upd.state;
      out_motor_r   <= upd.motor;
      out_changed_r <= upd.changed;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_shutter_state  = out_state_r;
  assign out_motor_cmd      = out_motor_r;
  assign out_status_changed = out_changed_r;

  // Drive open is only issued while the shutter stays opening
  a_drive_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_motor_r == MOT_OPEN |-> out_state_r == SH_OPENING)
    else $error("drive open outside opening");

  // A stop always comes with a status report
  a_stop_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_motor_r == MOT_STOP |-> out_changed_r)
    else $error("stop without status report");

  // Starting a run clears the count
  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    req_take && upd.motor == MOT_NONE &&
    (upd.state == SH_OPENING || upd.state == SH_CLOSING) |=> elapsed_r == '0)
    else $error("run start without cleared count");

  // An empty result register never blocks the input side
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

// ===== tb/sv/shutter_motor_controller_core_tb.sv =====
module shutter_motor_controller_core_tb;
  import smc_pkg::*;

  localparam int ResultLatency = 2;
  localparam int QuietLimit    = 5000;
  localparam int LongHold      = 300;
  localparam int ReportLimit   = 10;

  // One expected status report
  typedef struct packed {
    state_t state;
    motor_t motor;
    logic   changed;
  } shutter_status_t;

  logic              clk                = 1'b0;
  logic              rst_n              = 1'b0;
  logic              cfg_valid          = 1'b0;
  logic              cfg_ready;
  logic [CountW-1:0] cfg_run_timeout    = '0;
  logic              in_valid           = 1'b0;
  logic              in_ready;
  logic [1:0]        in_command         = CMD_NONE;
  logic              in_closed_switch   = 1'b0;
  logic              in_open_switch     = 1'b0;
  logic              in_ms_tick         = 1'b0;
  logic              out_valid;
  logic              out_ready          = 1'b0;
  logic [2:0]        out_shutter_state;
  logic [1:0]        out_motor_cmd;
  logic              out_status_changed;

  // Shadow of the shutter machine
  state_t            shutter_mode = SH_ABORTED;
  logic [CountW-1:0] run_ms       = '0;
  logic [CountW-1:0] run_timeout  = TimeoutReset;
  shutter_status_t   pending_status[$];

  int mismatch_count = 0;
  int requests_sent  = 0;
  int quiet_cycles   = 0;

  // Sender pacing
  int burst_left    = 0;
  bit sender_steady = 1'b0;

  // Receiver pacing and long hold-off requests
  int hold_requests = 0;
  int holds_started = 0;
  int hold_left     = 0;
  int ready_cycle   = 0;

  always #6 clk = ~clk;

  shutter_motor_controller_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_run_timeout    (cfg_run_timeout),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_closed_switch   (in_closed_switch),
    .in_open_switch     (in_open_switch),
    .in_ms_tick         (in_ms_tick),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_shutter_state  (out_shutter_state),
    .out_motor_cmd      (out_motor_cmd),
    .out_status_changed (out_status_changed)
  );

  // Enter a run: count restarts, tick of this request is not counted
  function automatic void begin_run(state_t next);
    shutter_mode = next;
    run_ms = '0;
  endfunction

  // One update of the shadow machine; returns the expected report
  function automatic shutter_status_t advance_shutter(cmd_t cmd, logic sw_closed,
                                                      logic sw_open, logic tick);
    shutter_status_t upd;
    logic            opening;
    logic            end_sw;
    cmd_t            opposing;
    upd.motor   = MOT_NONE;
    upd.changed = 1'b0;
    case (shutter_mode)
      SH_CLOSED: begin
        if (cmd == CMD_OPEN) begin
          begin_run(SH_OPENING);
          upd.changed = 1'b1;
        end
      end
      SH_OPEN: begin
        if (cmd == CMD_CLOSE) begin
          begin_run(SH_CLOSING);
          upd.changed = 1'b1;
        end
      end
      SH_OPENING, SH_CLOSING: begin
        opening  = (shutter_mode == SH_OPENING);
        end_sw   = opening ? sw_open : sw_closed;
        opposing = opening ? CMD_CLOSE : CMD_OPEN;
        if (tick && run_ms != CountMax)
          run_ms = run_ms + 1'b1;
        // limit switch first, then abort/opposing, then timeout
        if (end_sw) begin
          shutter_mode = opening ? SH_OPEN : SH_CLOSED;
          upd.motor    = MOT_STOP;
          upd.changed  = 1'b1;
        end else if (cmd == CMD_ABORT || cmd == opposing) begin
          shutter_mode = SH_ABORTED;
          upd.motor    = MOT_STOP;
          upd.changed  = 1'b1;
        end else if (run_ms > run_timeout) begin
          shutter_mode = SH_FAULT;
          upd.motor    = MOT_STOP;
          upd.changed  = 1'b1;
        end else begin
          upd.motor = opening ? MOT_OPEN : MOT_CLOSE;
        end
      end
      default: begin
        // re-read the switches, closed wins, then obey open/close
        if (sw_closed)
          shutter_mode = SH_CLOSED;
        else if (sw_open)
          shutter_mode = SH_OPEN;
        else
          shutter_mode = SH_ABORTED;
        if (cmd == CMD_OPEN) begin
          begin_run(SH_OPENING);
          upd.changed = 1'b1;
        end else if (cmd == CMD_CLOSE) begin
          begin_run(SH_CLOSING);
          upd.changed = 1'b1;
        end
      end
    endcase
    upd.state = shutter_mode;
    return upd;
  endfunction

  // Compare results, track config writes, predict accepted requests
  always @(posedge clk) begin : status_check
    shutter_status_t want;
    if (!rst_n) begin
      shutter_mode = SH_ABORTED;
      run_ms       = '0;
      run_timeout  = TimeoutReset;
      pending_status.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_status.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display("unexpected result: state %0d motor %0d changed %0d",
                     out_shutter_state, out_motor_cmd, out_status_changed);
        end else begin
          want = pending_status.pop_front();
          if (out_shutter_state !== want.state || out_motor_cmd !== want.motor ||
              out_status_changed !== want.changed) begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit)
              $display("status mismatch: state %0d/%0d motor %0d/%0d changed %0d/%0d (exp/got)",
                       want.state, out_shutter_state, want.motor, out_motor_cmd,
                       want.changed, out_status_changed);
          end
        end
      end
      if (cfg_valid && cfg_ready)
        run_timeout = cfg_run_timeout;
      if (in_valid && in_ready)
        pending_status.push_back(advance_shutter(cmd_t'(in_command), in_closed_switch,
                                                 in_open_switch, in_ms_tick));
    end
  end

  // Receiver: long hold-offs on request, otherwise a rotating stall style
  always @(posedge clk) begin
    ready_cycle++;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (holds_started != hold_requests) begin
      holds_started++;
      hold_left = LongHold - 1;
      out_ready <= 1'b0;
    end else begin
      case (ready_cycle[8:7])
        2'd0:    out_ready <= 1'b1;
        2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
        2'd2:    out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (ready_cycle % 5 != 0);
      endcase
    end
  end

  // Watchdog: too long without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one update request and wait until it is taken
  task automatic offer_update(cmd_t cmd, logic sw_closed, logic sw_open, logic tick);
    int gap;
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_closed_switch <= sw_closed;
    in_open_switch   <= sw_open;
    in_ms_tick       <= tick;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
    // bursts of random length, random gaps with junk payload
    if (!sender_steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(0, 5);
        if (gap > 0) begin
          in_valid         <= 1'b0;
          in_command       <= cmd_t'($urandom_range(0, 3));
          in_closed_switch <= 1'($urandom_range(0, 1));
          in_open_switch   <= 1'($urandom_range(0, 1));
          in_ms_tick       <= 1'($urandom_range(0, 1));
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
  endtask

  // Stop sending and wait until every report is back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_status.size() != 0) @(posedge clk);
    repeat (ResultLatency) @(posedge clk);
  endtask

  // Only called while idle
  task automatic set_run_timeout(logic [CountW-1:0] limit_ms);
    cfg_valid       <= 1'b1;
    cfg_run_timeout <= limit_ms;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Aborted after reset: abort ignored, switches re-read without report, a close run aborted, closed wins
  task automatic test_switch_reread();
    offer_update(CMD_NONE, 1'b0, 1'b0, 1'b0);
    offer_update(CMD_ABORT, 1'b0, 1'b0, 1'b1);
    offer_update(CMD_NONE, 1'b0, 1'b1, 1'b0);
    offer_update(CMD_CLOSE, 1'b1, 1'b0, 1'b1);
    offer_update(CMD_ABORT, 1'b0, 1'b0, 1'b0);
    offer_update(CMD_NONE, 1'b1, 1'b1, 1'b0);
  endtask

  // Ignored commands at rest and runs ended by limit switch, opposing command and abort
  task automatic test_run_endings();
    offer_update(CMD_CLOSE, 1'b1, 1'b0, 1'b0);
    offer_update(CMD_ABORT, 1'b1, 1'b0, 1'b1);
    offer_update(CMD_OPEN, 1'b1, 1'b0, 1'b1);
    offer_update(CMD_OPEN, 1'b0, 1'b0, 1'b1);
    offer_update(CMD_NONE, 1'b1, 1'b1, 1'b0);
    offer_update(CMD_OPEN, 1'b0, 1'b1, 1'b0);
    offer_update(CMD_CLOSE, 1'b0, 1'b1, 1'b1);
    offer_update(CMD_OPEN, 1'b0, 1'b0, 1'b1);
    offer_update(CMD_CLOSE, 1'b0, 1'b0, 1'b0);
    offer_update(CMD_NONE, 1'b1, 1'b1, 1'b1);
    offer_update(CMD_OPEN, 1'b0, 1'b0, 1'b0);
    offer_update(CMD_ABORT, 1'b0, 1'b0, 1'b0);
  endtask

  // A timeout of one ms into error, then the longest (never fires)
  task automatic test_run_timeout();
    wait_for_results();
    set_run_timeout(CountW'(1));
    offer_update(CMD_OPEN, 1'b1, 1'b0, 1'b1);
    offer_update(CMD_NONE, 1'b0, 1'b0, 1'b1);
    offer_update(CMD_NONE, 1'b0, 1'b0, 1'b0);
    offer_update(CMD_NONE, 1'b0, 1'b0, 1'b1);
    offer_update(CMD_NONE, 1'b0, 1'b0, 1'b0);
    wait_for_results();
    set_run_timeout(CountMax);
    offer_update(CMD_CLOSE, 1'b0, 1'b0, 1'b1);
    offer_update(CMD_NONE, 1'b0, 1'b0, 1'b1);
    offer_update(CMD_NONE, 1'b0, 1'b0, 1'b1);
    offer_update(CMD_NONE, 1'b1, 1'b0, 1'b1);
  endtask

  // A plausible run: optional re-read, start, travel, an ending most of the time
  task automatic run_episode();
    logic to_open;
    cmd_t start_cmd;
    cmd_t opposing;
    int   run_len;
    int   ending;
    to_open   = 1'($urandom_range(0, 1));
    start_cmd = to_open ? CMD_OPEN : CMD_CLOSE;
    opposing  = to_open ? CMD_CLOSE : CMD_OPEN;
    if ($urandom_range(0, 3) == 0)
      offer_update(CMD_NONE, !to_open, to_open, 1'($urandom_range(0, 1)));
    offer_update(start_cmd, 1'b0, 1'b0, 1'($urandom_range(0, 1)));
    run_len = $urandom_range(0, 20);
    repeat (run_len) begin
      if ($urandom_range(0, 15) == 0)
        offer_update(cmd_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else
        offer_update(CMD_NONE, 1'b0, 1'b0, $urandom_range(0, 3) != 0);
    end
    ending = $urandom_range(0, 9);
    if (ending <= 5)
      offer_update(CMD_NONE, !to_open, to_open, 1'($urandom_range(0, 1)));
    else if (ending == 6)
      offer_update(CMD_NONE, 1'b1, 1'b1, 1'($urandom_range(0, 1)));
    else if (ending == 7)
      offer_update(CMD_ABORT, 1'b0, 1'b0, 1'($urandom_range(0, 1)));
    else if (ending == 8)
      offer_update(opposing, 1'b0, 1'b0, 1'($urandom_range(0, 1)));
  endtask

  // One random phase at a given timeout
  task automatic random_phase(logic [CountW-1:0] limit_ms, int n_requests, bit steady,
                              bit long_hold, bit pause_midway);
    int stop_at;
    int pause_at;
    wait_for_results();
    set_run_timeout(limit_ms);
    sender_steady = steady;
    if (long_hold)
      hold_requests++;
    stop_at  = requests_sent + n_requests;
    pause_at = requests_sent + n_requests / 2;
    while (requests_sent < stop_at) begin
      if (pause_midway && requests_sent >= pause_at) begin
        wait_for_results();
        pause_midway = 1'b0;
      end
      if ($urandom_range(0, 9) < 8)
        run_episode();
      else
        offer_update(cmd_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    sender_steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    random_phase(CountW'($urandom_range(1, 12)), 110, 1'b0, 1'b0, 1'b1);
    random_phase(CountMax, 70, 1'b1, 1'b1, 1'b0);
    random_phase(CountW'($urandom_range(13, 40)), 100, 1'b0, 1'b1, 1'b0);
    random_phase(TimeoutReset, 60, 1'b0, 1'b0, 1'b0);
    random_phase(CountW'($urandom_range(1, 30)), 100, 1'b1, 1'b0, 1'b1);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_switch_reread();
    test_run_endings();
    test_run_timeout();
    test_random_traffic();
    wait_for_results();
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
design/smc_pkg.sv
design/smc_in_stage.sv
design/smc_step.sv
design/shutter_motor_controller_core.sv
tb/sv/shutter_motor_controller_core_tb.sv
